[hdl/ppm_pkg.sv]
`default_nettype none

package ppm_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 16;
    localparam int LIM_W      = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int TIMEOUT_W  = 32;
    localparam int NUM_SENS   = 4;
    localparam int SENS_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FRAC_BITS  = 15;

    localparam logic [VALUE_W-1:0] ONE_FX = VALUE_W'(32768);

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam logic [TIMEOUT_W-1:0] DEF_TIMEOUT = TIMEOUT_W'(100);
    localparam logic [LIM_W-1:0]     DEF_DELTA   = LIM_W'(3277);
    localparam logic [LIM_W-1:0]     DEF_CUT     = LIM_W'(8192);
    localparam logic [LIM_W-1:0]     DEF_RELEASE = LIM_W'(1638);

    typedef enum logic [STATUS_W-1:0] {
        ST_CONFIG_INVALID = 2'd0,
        ST_SAMPLE_INVALID = 2'd1,
        ST_VALID          = 2'd2
    } sensor_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APPS1   = 3'd0,
        REG_APPS2   = 3'd1,
        REG_BRAKE_F = 3'd2,
        REG_BRAKE_R = 3'd3,
        REG_TIMEOUT = 3'd4,
        REG_DELTA   = 3'd5,
        REG_CUT     = 3'd6,
        REG_RELEASE = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_DIV,
        S_UPD_FLAGS,
        S_UPD_SPAN,
        S_UPD_TIME,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

[hdl/ppm_in_if.sv]
`default_nettype none

interface ppm_in_if;
    import ppm_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [SENS_W-1:0]   sensor_index;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_previous;
    logic [TIME_W-1:0]   time_current;

    modport source (
        output valid, cmd, sensor_index, sample, time_previous, time_current,
        input  ready
    );

    modport sink (
        input  valid, cmd, sensor_index, sample, time_previous, time_current,
        output ready
    );
endinterface

`default_nettype wire

[hdl/ppm_out_if.sv]
`default_nettype none

interface ppm_out_if;
    import ppm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] sensor_status;
    logic [VALUE_W-1:0]  sensor_value;
    logic [VALUE_W-1:0]  accel_request;
    logic [VALUE_W-1:0]  brake_request;
    logic                accelerating;
    logic                braking;
    logic                accel_sensors_agree;
    logic                accel_brake_ok;
    logic                plausible_now;
    logic                plausible;

    modport source (
        output valid, sensor_status, sensor_value, accel_request, brake_request,
               accelerating, braking, accel_sensors_agree, accel_brake_ok,
               plausible_now, plausible,
        input  ready
    );

    modport sink (
        input  valid, sensor_status, sensor_value, accel_request, brake_request,
               accelerating, braking, accel_sensors_agree, accel_brake_ok,
               plausible_now, plausible,
        output ready
    );
endinterface

`default_nettype wire

[hdl/pedal_plausibility_monitor.sv]
// Channel   Dir   Handshake      Payload
// item      in    valid/ready    cmd, sensor_index, sample, time_previous, time_current
// result    out   valid/ready    sensor status/value, requests, check flags
// cfg       in    cfg_we         cfg_index, cfg_data (no back-pressure)
//
// One request at a time; item.ready is high only when the sequencer is idle.
// Sample request: conversion checks, then a 15-step restoring divider (one quotient
// bit per cycle) when the sample lies inside the request range. Update request:
// flags, deadline span, deadline compare/update. A finished result waits in the
// output register; a stalled result holds the sequencer in its last step. Reset
// clears all but the request, divider and payload registers; no clearing pass.
`default_nettype none

module pedal_plausibility_monitor #(
    parameter int SAMPLE_BITS = ppm_pkg::DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = ppm_pkg::DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]  cfg_data,
    ppm_in_if.sink                          item,
    ppm_out_if.source                       result
);
    import ppm_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);

    // configuration
    logic [CFG_DATA_W-1:0] limits_reg [NUM_SENS];
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [LIM_W-1:0]      delta_reg;
    logic [LIM_W-1:0]      cut_reg;
    logic [LIM_W-1:0]      release_reg;

    // sensor and update state
    logic [VALUE_W-1:0]    sens_val_reg [NUM_SENS];
    sensor_status_t        sens_st_reg  [NUM_SENS];
    logic [VALUE_W-1:0]    accel_avg_reg;
    logic [VALUE_W-1:0]    brake_avg_reg;
    logic                  accel_f_reg;
    logic                  brake_f_reg;
    logic                  agree_f_reg;
    logic                  latch_f_reg;
    logic                  now_f_reg;
    logic                  plaus_f_reg;
    logic [TIME_BITS-1:0]  deadline_reg;

    // captured request
    logic [SENS_W-1:0]     idx_reg;
    logic [SAMPLE_W-1:0]   smp_reg;
    logic [TIME_BITS-1:0]  tprev_reg;
    logic [TIME_BITS-1:0]  tcur_reg;

    // shared divider and time span
    logic [LIM_W-1:0]      rem_reg;
    logic [LIM_W-1:0]      dvs_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TIME_BITS-1:0]  span_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    logic [VALUE_W-1:0]    res_accel_reg;
    logic [VALUE_W-1:0]    res_brake_reg;
    logic [5:0]            res_flags_reg;

    seq_state_t            state_reg;
    seq_state_t            state_next;

    // sequencer strobes
    logic accept;
    logic do_conv;
    logic do_div;
    logic do_flags;
    logic do_span;
    logic do_time;
    logic load_out;

    // ---------------------------------------------------------------
    // limit decode
    logic [LIM_W-1:0] amin [NUM_SENS];
    logic [LIM_W-1:0] rmin [NUM_SENS];
    logic [LIM_W-1:0] rmax [NUM_SENS];
    logic [LIM_W-1:0] amax [NUM_SENS];
    logic [NUM_SENS-1:0] cfg_ok;
    sensor_status_t      status_of [NUM_SENS];

    always_comb
    begin
        for (int i = 0; i < NUM_SENS; i++)
        begin
            amin[i]      = limits_reg[i][0*LIM_W +: LIM_W];
            rmin[i]      = limits_reg[i][1*LIM_W +: LIM_W];
            rmax[i]      = limits_reg[i][2*LIM_W +: LIM_W];
            amax[i]      = limits_reg[i][3*LIM_W +: LIM_W];
            cfg_ok[i]    = (amin[i] < rmin[i]) && (rmin[i] < rmax[i]) && (rmax[i] < amax[i]);
            status_of[i] = cfg_ok[i] ? sens_st_reg[i] : ST_CONFIG_INVALID;
        end
    end

    // ---------------------------------------------------------------
    // sample conversion checks
    logic             conv_range_bad;
    logic             conv_below;
    logic             conv_inside;
    logic             conv_divide;
    logic [LIM_W-1:0] conv_num;
    logic [LIM_W-1:0] conv_den;

    always_comb
    begin
        conv_range_bad = (smp_reg < amin[idx_reg]) || (smp_reg > amax[idx_reg]);
        conv_below     = smp_reg < rmin[idx_reg];
        conv_inside    = smp_reg < rmax[idx_reg];
        conv_num       = smp_reg - rmin[idx_reg];
        conv_den       = rmax[idx_reg] - rmin[idx_reg];
        conv_divide    = cfg_ok[idx_reg] && !conv_range_bad && !conv_below && conv_inside;
    end

    // restoring divide step; remainder stays below divisor
    logic [LIM_W:0]   div_r2;
    logic [LIM_W:0]   div_diff;
    logic             div_ge;
    logic [LIM_W-1:0] rem_next;
    logic             div_last;

    always_comb
    begin
        div_r2   = {rem_reg, 1'b0};
        div_diff = div_r2 - {1'b0, dvs_reg};
        div_ge   = div_r2 >= {1'b0, dvs_reg};
        rem_next = div_ge ? div_diff[LIM_W-1:0] : div_r2[LIM_W-1:0];
        div_last = cnt_reg == CNT_W'(FRAC_BITS - 1);
    end

    // ---------------------------------------------------------------
    // update arithmetic
    logic [VALUE_W:0]   asum;
    logic [VALUE_W:0]   bsum;
    logic [VALUE_W-1:0] adiff;
    logic               upd_agree;
    logic               upd_latch;
    logic               upd_now;
    logic [TIME_BITS-1:0] elapsed;

    always_comb
    begin
        asum  = {1'b0, sens_val_reg[0]} + {1'b0, sens_val_reg[1]};
        bsum  = {1'b0, sens_val_reg[2]} + {1'b0, sens_val_reg[3]};
        adiff = (sens_val_reg[0] > sens_val_reg[1]) ? sens_val_reg[0] - sens_val_reg[1]
                                                     : sens_val_reg[1] - sens_val_reg[0];
        upd_agree = adiff <= delta_reg;
        upd_latch = latch_f_reg;
        if ((asum > {cut_reg, 1'b0}) && (bsum != '0))
            upd_latch = 1'b0;
        else if (asum < {release_reg, 1'b0})
            upd_latch = 1'b1;
        upd_now = (status_of[0] == ST_VALID) && (status_of[1] == ST_VALID) &&
                  (status_of[2] == ST_VALID) && (status_of[3] == ST_VALID) &&
                  upd_agree && upd_latch;
        elapsed = tcur_reg - tprev_reg;
    end

    // ---------------------------------------------------------------
    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                    state_next = (cmd_t'(item.cmd) == CMD_UPDATE) ? S_UPD_FLAGS : S_CONV;
            end
            S_CONV:      state_next = conv_divide ? S_DIV : S_DONE;
            S_DIV:
            begin
                if (div_last)
                    state_next = S_DONE;
            end
            S_UPD_FLAGS: state_next = S_UPD_SPAN;
            S_UPD_SPAN:  state_next = S_UPD_TIME;
            S_UPD_TIME:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready = 1'b0;
        do_conv    = 1'b0;
        do_div     = 1'b0;
        do_flags   = 1'b0;
        do_span    = 1'b0;
        do_time    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:      item.ready = 1'b1;
            S_CONV:      do_conv    = 1'b1;
            S_DIV:       do_div     = 1'b1;
            S_UPD_FLAGS: do_flags   = 1'b1;
            S_UPD_SPAN:  do_span    = 1'b1;
            S_UPD_TIME:  do_time    = 1'b1;
            S_DONE:      load_out   = !out_valid_reg || result.ready;
            default:     item.ready = 1'b0;
        endcase
    end

    assign accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------
    // configuration and persistent state
    cfg_reg_t cfg_sel;
    assign cfg_sel = cfg_reg_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENS; i++)
            begin
                limits_reg[i]   <= '0;
                sens_val_reg[i] <= '0;
                sens_st_reg[i]  <= ST_SAMPLE_INVALID;
            end
            timeout_reg   <= DEF_TIMEOUT;
            delta_reg     <= DEF_DELTA;
            cut_reg       <= DEF_CUT;
            release_reg   <= DEF_RELEASE;
            accel_avg_reg <= '0;
            brake_avg_reg <= '0;
            accel_f_reg   <= 1'b0;
            brake_f_reg   <= 1'b0;
            agree_f_reg   <= 1'b0;
            latch_f_reg   <= 1'b0;
            now_f_reg     <= 1'b0;
            plaus_f_reg   <= 1'b0;
            deadline_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_sel) inside
                    REG_APPS1, REG_APPS2, REG_BRAKE_F, REG_BRAKE_R:
                    begin
                        limits_reg[cfg_index[SENS_W-1:0]]   <= cfg_data;
                        sens_st_reg[cfg_index[SENS_W-1:0]]  <= ST_SAMPLE_INVALID;
                        sens_val_reg[cfg_index[SENS_W-1:0]] <= '0;
                    end
                    REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    REG_DELTA:   delta_reg   <= cfg_data[LIM_W-1:0];
                    REG_CUT:     cut_reg     <= cfg_data[LIM_W-1:0];
                    REG_RELEASE: release_reg <= cfg_data[LIM_W-1:0];
                endcase
            end

            if (do_conv)
            begin
                if (!cfg_ok[idx_reg])
                    sens_val_reg[idx_reg] <= '0;
                else if (conv_range_bad)
                begin
                    sens_st_reg[idx_reg]  <= ST_SAMPLE_INVALID;
                    sens_val_reg[idx_reg] <= '0;
                end
                else
                begin
                    sens_st_reg[idx_reg] <= ST_VALID;
                    if (conv_below)
                        sens_val_reg[idx_reg] <= '0;
                    else if (!conv_inside)
                        sens_val_reg[idx_reg] <= ONE_FX;
                end
            end

            if (do_div && div_last)
                sens_val_reg[idx_reg] <= VALUE_W'({quo_reg[FRAC_BITS-2:0], div_ge});

            if (do_flags)
            begin
                accel_avg_reg <= asum[VALUE_W:1];
                brake_avg_reg <= bsum[VALUE_W:1];
                accel_f_reg   <= asum != '0;
                brake_f_reg   <= bsum != '0;
                agree_f_reg   <= upd_agree;
                latch_f_reg   <= upd_latch;
                now_f_reg     <= upd_now;
            end

            if (do_time)
            begin
                if (now_f_reg)
                begin
                    plaus_f_reg  <= 1'b1;
                    deadline_reg <= tcur_reg + TIME_BITS'(timeout_reg);
                end
                else if (span_reg < elapsed)
                    plaus_f_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // request capture, divider and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= item.sensor_index;
            smp_reg   <= SAMPLE_W'(item.sample[SAMPLE_BITS-1:0]);
            tprev_reg <= TIME_BITS'(item.time_previous);
            tcur_reg  <= TIME_BITS'(item.time_current);
        end

        if (do_conv)
        begin
            rem_reg <= conv_num;
            dvs_reg <= conv_den;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (do_div)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], div_ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (do_span)
            span_reg <= deadline_reg - tprev_reg;

        if (load_out)
        begin
            res_status_reg <= status_of[idx_reg];
            res_value_reg  <= sens_val_reg[idx_reg];
            res_accel_reg  <= accel_avg_reg;
            res_brake_reg  <= brake_avg_reg;
            res_flags_reg  <= {plaus_f_reg, now_f_reg, latch_f_reg,
                               agree_f_reg, brake_f_reg, accel_f_reg};
        end
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign result.valid               = out_valid_reg;
    assign result.sensor_status       = res_status_reg;
    assign result.sensor_value        = res_value_reg;
    assign result.accel_request       = res_accel_reg;
    assign result.brake_request       = res_brake_reg;
    assign result.accelerating        = res_flags_reg[0];
    assign result.braking             = res_flags_reg[1];
    assign result.accel_sensors_agree = res_flags_reg[2];
    assign result.accel_brake_ok      = res_flags_reg[3];
    assign result.plausible_now       = res_flags_reg[4];
    assign result.plausible           = res_flags_reg[5];

endmodule

`default_nettype wire

[hdl/ppm_checker.sv]
`default_nettype none

module ppm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [ppm_pkg::STATUS_W-1:0]    sensor_status,
    input logic [ppm_pkg::VALUE_W-1:0]     sensor_value,
    input logic [ppm_pkg::VALUE_W-1:0]     accel_request,
    input logic [ppm_pkg::VALUE_W-1:0]     brake_request,
    input logic                            accel_sensors_agree,
    input logic                            accel_brake_ok,
    input logic                            plausible_now,
    input logic                            plausible
);
    import ppm_pkg::*;

    // stalled result must hold
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(sensor_status) && $stable(sensor_value) &&
            $stable(accel_request) && $stable(brake_request) && $stable(plausible))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accept");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sensor_value <= ONE_FX && accel_request <= ONE_FX &&
                         brake_request <= ONE_FX)
        else $error("position beyond full travel");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sensor_status != ST_VALID |-> sensor_value == '0)
        else $error("invalid sensor with nonzero position");

    a_now_implies: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && plausible_now |->
            plausible && accel_sensors_agree && accel_brake_ok)
        else $error("plausible_now without its checks");

endmodule

bind pedal_plausibility_monitor ppm_checker u_ppm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .sensor_status       (result.sensor_status),
    .sensor_value        (result.sensor_value),
    .accel_request       (result.accel_request),
    .brake_request       (result.brake_request),
    .accel_sensors_agree (result.accel_sensors_agree),
    .accel_brake_ok      (result.accel_brake_ok),
    .plausible_now       (result.plausible_now),
    .plausible           (result.plausible)
);

`default_nettype wire

[bench/pedal_plausibility_monitor_tb.sv]
module pedal_plausibility_monitor_tb;
    import ppm_pkg::*;

    typedef struct packed {
        cmd_t                cmd;
        logic [SENS_W-1:0]   sensor;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   t_prev;
        logic [TIME_W-1:0]   t_cur;
    } pedal_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  accel_req;
        logic [VALUE_W-1:0]  brake_req;
        logic                accelerating;
        logic                braking;
        logic                agree;
        logic                ab_ok;
        logic                plaus_now;
        logic                plaus;
    } pedal_result_t;

    class pedal_scoreboard;
        bit [63:0]      limits [NUM_SENS];
        bit [31:0]      timeout_ticks;
        bit [15:0]      delta_limit;
        bit [15:0]      cut_level;
        bit [15:0]      release_level;
        bit [15:0]      position [NUM_SENS];
        sensor_status_t state [NUM_SENS];
        bit [15:0]      accel_avg;
        bit [15:0]      brake_avg;
        bit             f_accel, f_brake, f_agree, f_latch, f_now, f_plaus;
        bit [31:0]      deadline;
        pedal_result_t  expected_q [$];
        int             errors, n_checked, n_sample, n_update, n_now, n_drops;

        function new();
            for (int i = 0; i < NUM_SENS; i++)
            begin
                limits[i]   = '0;
                position[i] = '0;
                state[i]    = ST_SAMPLE_INVALID;
            end
            timeout_ticks = DEF_TIMEOUT;
            delta_limit   = DEF_DELTA;
            cut_level     = DEF_CUT;
            release_level = DEF_RELEASE;
        endfunction

        function bit [15:0] lim(int s, int part);
            return limits[s][16*part +: 16];
        endfunction

        function bit config_ok(int s);
            return lim(s, 0) < lim(s, 1) && lim(s, 1) < lim(s, 2) && lim(s, 2) < lim(s, 3);
        endfunction

        function sensor_status_t status_of(int s);
            return config_ok(s) ? state[s] : ST_CONFIG_INVALID;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(cfg_reg_t r, bit [63:0] v);
            case (r)
                REG_APPS1, REG_APPS2, REG_BRAKE_F, REG_BRAKE_R:
                begin
                    limits[int'(r)]   = v;
                    state[int'(r)]    = ST_SAMPLE_INVALID;
                    position[int'(r)] = '0;
                end
                REG_TIMEOUT: timeout_ticks = v[31:0];
                REG_DELTA:   delta_limit   = v[15:0];
                REG_CUT:     cut_level     = v[15:0];
                REG_RELEASE: release_level = v[15:0];
                default: ;
            endcase
        endfunction

        function void convert(int s, bit [15:0] smp);
            bit [31:0] num;
            if (!config_ok(s))
            begin
                position[s] = '0;
                return;
            end
            if (smp < lim(s, 0) || smp > lim(s, 3))
            begin
                state[s]    = ST_SAMPLE_INVALID;
                position[s] = '0;
                return;
            end
            state[s] = ST_VALID;
            if (smp < lim(s, 1))
                position[s] = '0;
            else if (smp < lim(s, 2))
            begin
                num = (32'(smp) - 32'(lim(s, 1))) << FRAC_BITS;
                position[s] = 16'(num / (32'(lim(s, 2)) - 32'(lim(s, 1))));
            end
            else
                position[s] = ONE_FX;
        endfunction

        function void judge(bit [31:0] tprev, bit [31:0] tcur);
            bit [31:0] asum, bsum, diff, span_left, span_step;
            bit        was_plausible;
            asum = 32'(position[0]) + 32'(position[1]);
            bsum = 32'(position[2]) + 32'(position[3]);
            diff = (position[0] > position[1]) ? 32'(position[0]) - 32'(position[1])
                                               : 32'(position[1]) - 32'(position[0]);
            accel_avg = 16'(asum >> 1);
            brake_avg = 16'(bsum >> 1);
            f_accel = (asum != 0);
            f_brake = (bsum != 0);
            f_agree = (diff <= 32'(delta_limit));
            // 25/5 latch: sums against doubled thresholds, no rounding
            if (asum > (32'(cut_level) << 1) && f_brake)
                f_latch = 1'b0;
            else if (asum < (32'(release_level) << 1))
                f_latch = 1'b1;
            f_now = status_of(0) == ST_VALID && status_of(1) == ST_VALID &&
                    status_of(2) == ST_VALID && status_of(3) == ST_VALID &&
                    f_agree && f_latch;
            was_plausible = f_plaus;
            span_left = deadline - tprev;
            span_step = tcur - tprev;
            if (f_now)
            begin
                f_plaus  = 1'b1;
                deadline = tcur + timeout_ticks;
                n_now++;
            end
            else if (span_left < span_step)
                f_plaus = 1'b0;
            if (was_plausible && !f_plaus)
                n_drops++;
        endfunction

        function void note_request(pedal_req_t r);
            pedal_result_t e;
            if (r.cmd == CMD_SAMPLE)
            begin
                convert(int'(r.sensor), r.sample);
                n_sample++;
            end
            else
            begin
                judge(r.t_prev, r.t_cur);
                n_update++;
            end
            e.status       = status_of(int'(r.sensor));
            e.value        = position[r.sensor];
            e.accel_req    = accel_avg;
            e.brake_req    = brake_avg;
            e.accelerating = f_accel;
            e.braking      = f_brake;
            e.agree        = f_agree;
            e.ab_ok        = f_latch;
            e.plaus_now    = f_now;
            e.plaus        = f_plaus;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 n_checked, name, got, want));
        endtask

        task check_result(pedal_result_t got);
            pedal_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result arrived with no request pending");
                return;
            end
            want = expected_q.pop_front();
            compare_field("sensor_status", 16'(got.status), 16'(want.status));
            compare_field("sensor_value", got.value, want.value);
            compare_field("accel_request", got.accel_req, want.accel_req);
            compare_field("brake_request", got.brake_req, want.brake_req);
            compare_field("accelerating", 16'(got.accelerating), 16'(want.accelerating));
            compare_field("braking", 16'(got.braking), 16'(want.braking));
            compare_field("accel_sensors_agree", 16'(got.agree), 16'(want.agree));
            compare_field("accel_brake_ok", 16'(got.ab_ok), 16'(want.ab_ok));
            compare_field("plausible_now", 16'(got.plaus_now), 16'(want.plaus_now));
            compare_field("plausible", 16'(got.plaus), 16'(want.plaus));
            n_checked++;
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ppm_in_if  item ();
    ppm_out_if result ();

    pedal_plausibility_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result)
    );

    pedal_scoreboard sb;
    bit [63:0]       reg_value [8];
    bit [31:0]       tick;
    int              sender_idle_pct;
    int              recv_stall_pct;
    bit              hold_arm;
    int              hold_left;
    int              n_settings;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TIMEOUT: requests still outstanding");
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check on accept, then choose next ready
    initial
    begin
        pedal_result_t got;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                got = '{status: result.sensor_status, value: result.sensor_value,
                        accel_req: result.accel_request, brake_req: result.brake_request,
                        accelerating: result.accelerating, braking: result.braking,
                        agree: result.accel_sensors_agree, ab_ok: result.accel_brake_ok,
                        plaus_now: result.plausible_now, plaus: result.plausible};
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (hold_arm)
            begin
                hold_arm  = 1'b0;
                hold_left = 299;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic bit [63:0] pack_limits(int amin, int rmin, int rmax, int amax);
        return {16'(amax), 16'(rmax), 16'(rmin), 16'(amin)};
    endfunction

    function automatic bit [63:0] random_limits();
        int a, b, c, d;
        a = $urandom_range(0, 16000);
        b = a + 1 + $urandom_range(0, 16000);
        c = b + 1 + $urandom_range(0, 16000);
        d = c + 1 + $urandom_range(0, 65535 - c - 1);
        return pack_limits(a, b, c, d);
    endfunction

    // raw sample that lands near a pedal position, kept inside the absolute range
    function automatic bit [15:0] sample_at(int s, int pos);
        longint lo, hi, amin, amax, v;
        if (!sb.config_ok(s))
            return 16'($urandom);
        amin = sb.lim(s, 0);
        lo   = sb.lim(s, 1);
        hi   = sb.lim(s, 2);
        amax = sb.lim(s, 3);
        v = lo + ((hi - lo) * pos) / 32768;
        if (v < amin)
            v = amin;
        if (v > amax)
            v = amax;
        return 16'(v);
    endfunction

    function automatic bit [15:0] wild_sample(int s);
        int amin, amax;
        amin = sb.lim(s, 0);
        amax = sb.lim(s, 3);
        if (amin > 0 && (amax == 65535 || $urandom_range(0, 1) == 1))
            return 16'($urandom_range(0, amin - 1));
        if (amax < 65535)
            return 16'($urandom_range(amax + 1, 65535));
        return 16'($urandom);
    endfunction

    task automatic load_nominal();
        reg_value[REG_APPS1]   = pack_limits(1000, 4000, 60000, 64000);
        reg_value[REG_APPS2]   = pack_limits(2000, 5000, 50000, 60000);
        reg_value[REG_BRAKE_F] = pack_limits(500, 3000, 40000, 62000);
        reg_value[REG_BRAKE_R] = pack_limits(500, 3000, 40000, 62000);
        reg_value[REG_TIMEOUT] = 64'(DEF_TIMEOUT);
        reg_value[REG_DELTA]   = 64'(DEF_DELTA);
        reg_value[REG_CUT]     = 64'(DEF_CUT);
        reg_value[REG_RELEASE] = 64'(DEF_RELEASE);
    endtask

    task automatic apply_regs(bit [7:0] which);
        for (int i = 0; i < 8; i++)
        begin
            if (which[i])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= cfg_reg_t'(i);
                cfg_data  <= reg_value[i];
                @(posedge clk);
                sb.write_register(cfg_reg_t'(i), reg_value[i]);
            end
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_request(pedal_req_t r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid         <= 1'b1;
        item.cmd           <= r.cmd;
        item.sensor_index  <= r.sensor;
        item.sample        <= r.sample;
        item.time_previous <= r.t_prev;
        item.time_current  <= r.t_cur;
        @(posedge clk);
        while (item.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_sample(int s, bit [15:0] smp);
        pedal_req_t r;
        r.cmd    = CMD_SAMPLE;
        r.sensor = SENS_W'(s);
        r.sample = smp;
        r.t_prev = $urandom;
        r.t_cur  = $urandom;
        send_request(r);
    endtask

    task automatic send_update(int s, bit [31:0] tp, bit [31:0] tc);
        pedal_req_t r;
        r.cmd    = CMD_UPDATE;
        r.sensor = SENS_W'(s);
        r.sample = $urandom;
        r.t_prev = tp;
        r.t_cur  = tc;
        send_request(r);
    endtask

    task automatic wait_idle();
        item.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly full frames: four samples then an update with advancing time
    task automatic run_traffic(int count);
        pedal_req_t r;
        int         sent, p, b, fault, bad, start, s, roll;
        int         pos [4];
        bit [31:0]  step;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                r.cmd    = cmd_t'($urandom_range(0, 1));
                r.sensor = SENS_W'($urandom);
                r.sample = SAMPLE_W'($urandom);
                r.t_prev = $urandom;
                r.t_cur  = $urandom;
                send_request(r);
                sent++;
            end
            else
            begin
                roll = $urandom_range(0, 3);
                if (roll == 0)
                    p = 0;
                else if (roll == 1)
                    p = $urandom_range(0, 1500);
                else if (roll == 2)
                    p = $urandom_range(0, 32768);
                else
                    p = $urandom_range(20000, 34000);
                b = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(100, 33000);
                pos[0] = p;
                pos[1] = p + int'($urandom_range(0, 600)) - 300;
                pos[2] = b;
                pos[3] = b + int'($urandom_range(0, 600)) - 300;
                fault = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 2) : 0;
                if (fault == 1)
                    pos[1] = 32768 - p;
                bad   = $urandom_range(0, 3);
                start = $urandom_range(0, 3);
                for (int k = 0; k < 4; k++)
                begin
                    s = (start + k) % 4;
                    if (fault == 2 && s == bad)
                        send_sample(s, wild_sample(s));
                    else
                        send_sample(s, sample_at(s, pos[s]));
                end
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    step = $urandom_range(1, 40);
                else if (roll < 9)
                    step = $urandom_range(40, 400);
                else
                    step = $urandom;
                send_update($urandom_range(0, 3), tick, tick + step);
                tick = tick + step;
                sent += 5;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_APPS1;
        cfg_data           <= '0;
        item.valid         <= 1'b0;
        item.cmd           <= CMD_SAMPLE;
        item.sensor_index  <= '0;
        item.sample        <= '0;
        item.time_previous <= '0;
        item.time_current  <= '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits are all zero, so every sensor is config invalid
        send_sample(0, 16'hFFFF);
        send_update(1, 32'h0, 32'h0);
        wait_idle();
        load_nominal();
        apply_regs(8'hFF);

        send_sample(0, 16'd0);
        send_sample(0, 16'hFFFF);
        send_sample(0, 16'd1000);
        send_sample(0, 16'd3999);
        send_sample(0, 16'd32000);
        send_sample(0, 16'd60000);
        send_sample(0, 16'd64000);
        send_sample(1, 16'd50000);
        send_sample(2, 16'd3000);
        send_sample(3, 16'd500);
        // hard accel, no brake: latch still clear from reset
        send_update(0, 32'd0, 32'd10);
        send_sample(0, 16'd4000);
        send_sample(1, 16'd5000);
        // pedal released: latch sets, plausible with deadline 120
        send_update(1, 32'd10, 32'd20);
        send_sample(2, 16'd40000);
        send_sample(0, 16'd60000);
        send_sample(1, 16'd50000);
        // accel with brake clears latch; still inside the deadline
        send_update(2, 32'd20, 32'd30);
        send_update(3, 32'd30, 32'd121);
        send_sample(1, 16'd5000);
        send_sample(2, 16'd3000);
        send_update(0, 32'hFFFF_FFFF, 32'h0000_0010);

        // equal limits make the sensor config invalid; rewriting resets it
        wait_idle();
        reg_value[REG_BRAKE_R] = pack_limits(500, 500, 40000, 62000);
        apply_regs(8'b0000_1000);
        send_sample(3, 16'd20000);
        wait_idle();
        reg_value[REG_BRAKE_R] = pack_limits(500, 3000, 40000, 62000);
        apply_regs(8'b0000_1000);
        send_update(3, 32'd200, 32'd210);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            load_nominal();
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    reg_value[REG_APPS1]   = pack_limits(0, 1, 65534, 65535);
                    reg_value[REG_TIMEOUT] = 64'd1;
                    reg_value[REG_DELTA]   = 64'd0;
                    reg_value[REG_CUT]     = 64'd0;
                    reg_value[REG_RELEASE] = 64'd32768;
                    sender_idle_pct = 70;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    for (int s = 0; s < NUM_SENS; s++)
                        reg_value[s] = random_limits();
                    reg_value[REG_TIMEOUT] = 64'hFFFF_FFFF;
                    reg_value[REG_DELTA]   = 64'd32768;
                    reg_value[REG_CUT]     = 64'd32768;
                    reg_value[REG_RELEASE] = 64'd0;
                    sender_idle_pct = 0;
                    recv_stall_pct  = 70;
                end
                3:
                begin
                    for (int s = 0; s < NUM_SENS; s++)
                        reg_value[s] = random_limits();
                    reg_value[REG_TIMEOUT] = 64'($urandom_range(1, 500));
                    reg_value[REG_DELTA]   = 64'($urandom_range(0, 32768));
                    reg_value[REG_CUT]     = 64'($urandom_range(0, 32768));
                    reg_value[REG_RELEASE] = 64'($urandom_range(0, 32768));
                    sender_idle_pct = 29;
                    recv_stall_pct  = 29;
                end
                4:
                begin
                    for (int s = 0; s < NUM_SENS; s++)
                        reg_value[s] = random_limits();
                    reg_value[REG_BRAKE_F] = {$urandom, $urandom};
                    reg_value[REG_TIMEOUT] = 64'($urandom_range(1, 200));
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                default:
                begin
                    sender_idle_pct = 29;
                    recv_stall_pct  = 29;
                end
            endcase
            apply_regs(8'hFF);
            tick = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                               : $urandom;
            if (phase == 0 || phase == 4)
                hold_arm = 1'b1;
            run_traffic(75);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        sb.close_out();
        $display("Summary: %0d requests (%0d sample, %0d update), %0d results checked, %0d register settings",
                 sb.n_sample + sb.n_update, sb.n_sample, sb.n_update, sb.n_checked, n_settings);
        $display("Summary: instantly plausible %0d times, plausible flag dropped %0d times",
                 sb.n_now, sb.n_drops);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
